// ===== sv/cdq_pkg.sv =====
// shared types for the circular deque: operation and status codes
package cdq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_POP_BACK   = 3'd1,
		OP_PUSH_FRONT = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_GET        = 3'd4,
		OP_SET        = 3'd5,
		OP_INSERT     = 3'd6,
		OP_DELETE     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

// ===== sv/cdq_ram.sv =====
// generic single-write single-read ram with registered read data
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/circular_deque_indexed.sv =====
// circular deque top level: request decode, shift sequencer and result register
//
// input channel: in_valid / in_stall carry one request (operation, position,
// word_in). output channel: out_valid / out_stall carry one result per request
// (word_out, status, occupancy).
// all words live in one synchronous ram with registered read data.
// push, set and refused requests go from accept straight to the emit state, which loads the result register.
// pop and get pass through the read state first (one ram read).
// insert and delete pass through the shift state, which moves m elements (m up to
// DEPTH - 1, none when nothing moves); the moves stream through the ram,
// one read and one write per cycle, the read address two slots ahead of the write.
// a new request is taken once the previous one has reached the result
// register, so a result waiting under out_stall does not block the input.
// while out_stall holds and a finished result is pending, the block waits.
// reset (arst_n low) empties the deque; ram contents are left as they are.
module circular_deque_indexed
	import cdq_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int WORD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          operation,
	input  logic [$clog2(DEPTH+1)-1:0]          position,
	input  logic signed [WORD_WIDTH-1:0]        word_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [WORD_WIDTH-1:0]        word_out,
	output logic [1:0]                          status,
	output logic [$clog2(DEPTH+1)-1:0]          occupancy
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SHIFT,
		S_EMIT
	} state_t;

	state_t                state_q, state_n;
	logic [PW-1:0]         head_q, tail_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         rd_left_q;
	logic                  rd_pend_s1;
	logic                  dir_up_q;
	logic                  ins_q;
	logic                  out_valid_q;
	logic [PW-1:0]         rd_ptr_q, wr_ptr_q, fin_addr_q;
	logic [WORD_WIDTH-1:0] word_q, res_word_q;
	status_t               res_status_q;
	logic [WORD_WIDTH-1:0] out_word_q;
	status_t               out_status_q;
	logic [CW-1:0]         out_occ_q;

	logic                  acc;
	logic                  load_out;
	logic                  shift_done;
	logic                  full, empty;
	op_t                   op;
	status_t               st_c;
	logic [SW-1:0]         sum;
	logic [PW-1:0]         slot_pos;
	logic [PW-1:0]         head_up, head_dn, tail_up, tail_dn;
	logic                  we, re;
	logic [PW-1:0]         waddr, raddr;
	logic [WORD_WIDTH-1:0] wdata, rdata;

	function automatic logic [PW-1:0] step_up(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] step_dn(input logic [PW-1:0] p);
		return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
	endfunction

	assign op         = op_t'(operation);
	assign acc        = (state_q == S_IDLE) && in_valid;
	assign in_stall   = (state_q != S_IDLE);
	assign load_out   = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign shift_done = (state_q == S_SHIFT) && (rd_left_q == '0) && !rd_pend_s1;
	assign full       = (count_q == CW'(DEPTH));
	assign empty      = (count_q == '0);
	assign head_up    = step_up(head_q);
	assign head_dn    = step_dn(head_q);
	assign tail_up    = step_up(tail_q);
	assign tail_dn    = step_dn(tail_q);

	always_comb begin
		sum = SW'(head_q) + SW'(position);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		slot_pos = sum[PW-1:0];
	end

	always_comb begin
		st_c    = ST_OK;
		state_n = state_q;
		we      = 1'b0;
		waddr   = wr_ptr_q;
		wdata   = rdata;
		re      = 1'b0;
		raddr   = rd_ptr_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_n = S_EMIT;
					case (op)
						OP_PUSH_BACK: begin
							if (full) begin
								st_c = ST_FULL;
							end else begin
								we    = 1'b1;
								waddr = tail_up;
								wdata = word_in;
							end
						end
						OP_POP_BACK: begin
							if (empty) begin
								st_c = ST_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = tail_q;
								state_n = S_READ;
							end
						end
						OP_PUSH_FRONT: begin
							if (full) begin
								st_c = ST_FULL;
							end else begin
								we    = 1'b1;
								waddr = head_dn;
								wdata = word_in;
							end
						end
						OP_POP_FRONT: begin
							if (empty) begin
								st_c = ST_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = head_q;
								state_n = S_READ;
							end
						end
						OP_GET: begin
							if (position >= count_q) begin
								st_c = ST_RANGE;
							end else begin
								re      = 1'b1;
								raddr   = slot_pos;
								state_n = S_READ;
							end
						end
						OP_SET: begin
							if (position >= count_q) begin
								st_c = ST_RANGE;
							end else begin
								we    = 1'b1;
								waddr = slot_pos;
								wdata = word_in;
							end
						end
						OP_INSERT: begin
							if (position > count_q) begin
								st_c = ST_RANGE;
							end else if (full) begin
								st_c = ST_FULL;
							end else begin
								state_n = S_SHIFT;
							end
						end
						OP_DELETE: begin
							if (position >= count_q) begin
								st_c = ST_RANGE;
							end else begin
								state_n = S_SHIFT;
							end
						end
						default: begin
							st_c = ST_OK;
						end
					endcase
				end
			end
			S_READ: begin
				state_n = S_EMIT;
			end
			S_SHIFT: begin
				re = (rd_left_q != '0);
				if (rd_pend_s1) begin
					we = 1'b1;
				end else if (rd_left_q == '0 && ins_q) begin
					we    = 1'b1;
					waddr = fin_addr_q;
					wdata = word_q;
				end
				if (shift_done) begin
					state_n = S_EMIT;
				end
			end
			S_EMIT: begin
				if (load_out) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	cdq_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= PW'(DEPTH - 1);
			count_q     <= '0;
			rd_left_q   <= '0;
			rd_pend_s1  <= 1'b0;
			dir_up_q    <= 1'b0;
			ins_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_n;
			rd_pend_s1 <= (state_q == S_SHIFT) && (rd_left_q != '0);
			if (state_q == S_SHIFT && rd_left_q != '0) begin
				rd_left_q <= rd_left_q - CW'(1);
			end
			if (acc && st_c == ST_OK) begin
				case (op)
					OP_PUSH_BACK: begin
						tail_q  <= tail_up;
						count_q <= count_q + CW'(1);
					end
					OP_POP_BACK: begin
						tail_q  <= tail_dn;
						count_q <= count_q - CW'(1);
					end
					OP_PUSH_FRONT: begin
						head_q  <= head_dn;
						count_q <= count_q + CW'(1);
					end
					OP_POP_FRONT: begin
						head_q  <= head_up;
						count_q <= count_q - CW'(1);
					end
					OP_INSERT: begin
						tail_q    <= tail_up;
						count_q   <= count_q + CW'(1);
						rd_left_q <= count_q - position;
						dir_up_q  <= 1'b0;
						ins_q     <= 1'b1;
					end
					OP_DELETE: begin
						tail_q    <= tail_dn;
						count_q   <= count_q - CW'(1);
						rd_left_q <= count_q - position - CW'(1);
						dir_up_q  <= 1'b1;
						ins_q     <= 1'b0;
					end
					default: begin
						ins_q <= 1'b0;
					end
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			word_q       <= word_in;
			fin_addr_q   <= slot_pos;
			res_status_q <= st_c;
			res_word_q   <= '0;
			if (op == OP_INSERT) begin
				rd_ptr_q <= tail_q;
				wr_ptr_q <= tail_up;
			end else begin
				rd_ptr_q <= step_up(slot_pos);
				wr_ptr_q <= slot_pos;
			end
		end
		if (state_q == S_READ) begin
			res_word_q <= rdata;
		end
		if (state_q == S_SHIFT) begin
			if (rd_left_q != '0) begin
				rd_ptr_q <= dir_up_q ? step_up(rd_ptr_q) : step_dn(rd_ptr_q);
			end
			if (rd_pend_s1) begin
				wr_ptr_q <= dir_up_q ? step_up(wr_ptr_q) : step_dn(wr_ptr_q);
			end
		end
		if (load_out) begin
			out_word_q   <= res_word_q;
			out_status_q <= res_status_q;
			out_occ_q    <= count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign word_out  = out_word_q;
	assign status    = out_status_q;
	assign occupancy = out_occ_q;

endmodule
